// ----- hw/rtl/llt_pkg.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// llt_pkg
// Shared types and constants for the line-locked text buffer.
// -----------------------------------------------------------------------------
package llt_pkg;

	localparam int IN_W  = 40;
	localparam int OUT_W = 8;

	localparam logic [6:0] KEY_BACKSPACE = 7'd7;
	localparam logic [6:0] KEY_COMMIT    = 7'd10;
	localparam logic [6:0] KEY_CANCEL    = 7'd27;
	localparam logic [6:0] KEY_PRINT_LO  = 7'd32;
	localparam logic [6:0] KEY_DELETE    = 7'd74;
	localparam logic [6:0] KEY_PRINT_HI  = 7'd126;

	localparam logic [7:0] CHAR_SPACE = 8'h20;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic rd_en;
		logic exec;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic out_full;
	} sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/line_locked_text_buffer.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// line_locked_text_buffer
// Shared text store with a working copy, a committed copy and a lock per line.
// -----------------------------------------------------------------------------
//
// Channel | Direction | Word content (from bit 0 up)
// --------+-----------+----------------------------------------------------
// s_*     | in        | client_id[15:0], line_index[3:0], column_index[5:0],
//         |           | key_code[6:0], zero pad to 40 bits
// m_*     | out       | status, lock_released, zero pad to 8 bits
//
// Each keystroke word has four steps: capture, row read, edit and
// write-back, result hand-over. The single-port row stores (one read or one
// write per cycle, registered read) put the read and the write-back in
// separate steps; a new word is taken only after the previous write-back.
// The result register lets the next word enter while a result is still
// waiting; if the sink stalls, the block waits in its last step.
// Reset is asynchronous and active low. It frees all locks and marks every
// row of both copies as unwritten, so they read as spaces at once: no
// clearing pass is needed.
//
// Denied words (line held by another client, or line beyond the store) leave
// everything unchanged and return status 0. A column beyond the row still
// claims the line, but an edit key there leaves the text as it is.
// -----------------------------------------------------------------------------
module line_locked_text_buffer #(
	parameter int LINES   = 16,
	parameter int COLUMNS = 64
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	// client_id[15:0], line_index[19:16], column_index[25:20], key_code[32:26]
	input  wire logic [llt_pkg::IN_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	// status[0], lock_released[1]
	output logic [llt_pkg::OUT_W-1:0]     m_tdata
);
	import llt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The sequencer only steps the datapath; all stored data lives there.
	llt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	llt_dp #(
		.LINES   (LINES),
		.COLUMNS (COLUMNS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/llt_ctrl.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// llt_ctrl
// Sequencer: capture, read the line, apply the edit, hand over the result.
// -----------------------------------------------------------------------------
module llt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic          m_tready,
	input  wire llt_pkg::sts_t sts,
	output llt_pkg::cmd_t      cmd
);
	import llt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				// The result register may still hold the previous word.
				if (!sts.out_full || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/llt_dp.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// llt_dp
// Datapath: row stores, owner locks, line edit logic and result register.
// -----------------------------------------------------------------------------
module llt_dp #(
	parameter int LINES   = 16,
	parameter int COLUMNS = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [llt_pkg::IN_W-1:0]  s_tdata,
	input  wire llt_pkg::cmd_t             cmd,
	output llt_pkg::sts_t                  sts,
	input  wire logic                      m_tready,
	output logic                           m_tvalid,
	output logic [llt_pkg::OUT_W-1:0]      m_tdata
);
	import llt_pkg::*;

	localparam int LW    = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int ROW_W = COLUMNS * 8;
	localparam logic [ROW_W-1:0] SPACE_ROW = {COLUMNS{CHAR_SPACE}};

	logic [15:0]     client_q;
	logic [3:0]      line_q;
	logic [5:0]      col_q;
	logic [6:0]      code_q;

	logic [ROW_W-1:0] work_mem [LINES];
	logic [ROW_W-1:0] cmt_mem  [LINES];
	logic [15:0]      own_mem  [LINES];
	logic [ROW_W-1:0] work_rd_s1;
	logic [ROW_W-1:0] cmt_rd_s1;
	logic [15:0]      own_rd_s1;

	logic [LINES-1:0] work_vld_q;
	logic [LINES-1:0] cmt_vld_q;
	logic [LINES-1:0] own_vld_q;

	logic res_status_q;
	logic res_rel_q;
	logic out_valid_q;
	logic out_status_q;
	logic out_rel_q;

	logic [8:0]       line_wide;
	logic [LW-1:0]    line_addr;
	logic             line_ok;
	logic             col_ok;
	logic             granted;
	logic             is_commit, is_cancel, is_delete, is_insert, is_bksp;
	logic             releases;
	logic [ROW_W-1:0] work_row;
	logic [ROW_W-1:0] cmt_row;
	logic [ROW_W-1:0] left_row;
	logic [ROW_W-1:0] right_row;
	logic [ROW_W-1:0] edited_row;
	logic             work_we;
	logic             cmt_we;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			client_q <= s_tdata[15:0];
			line_q   <= s_tdata[19:16];
			col_q    <= s_tdata[25:20];
			code_q   <= s_tdata[32:26];
		end
	end

	assign line_wide = {5'd0, line_q};
	assign line_addr = line_wide[LW-1:0];
	assign line_ok   = line_wide < 9'(LINES);
	assign col_ok    = {3'd0, col_q} < 9'(COLUMNS);

	// Row stores: one port each, registered read.
	always_ff @(posedge clk) begin
		if (work_we) begin
			work_mem[line_addr] <= (is_cancel) ? cmt_row : edited_row;
		end
		if (cmd.rd_en) begin
			work_rd_s1 <= work_mem[line_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmt_we) begin
			cmt_mem[line_addr] <= work_row;
		end
		if (cmd.rd_en) begin
			cmt_rd_s1 <= cmt_mem[line_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && granted) begin
			own_mem[line_addr] <= client_q;
		end
		if (cmd.rd_en) begin
			own_rd_s1 <= own_mem[line_addr];
		end
	end

	// A row never written reads as spaces.
	assign work_row = (line_ok && work_vld_q[line_addr]) ? work_rd_s1 : SPACE_ROW;
	assign cmt_row  = (line_ok && cmt_vld_q[line_addr])  ? cmt_rd_s1  : SPACE_ROW;

	assign granted = line_ok && !(own_vld_q[line_addr] && (own_rd_s1 != client_q));

	assign is_commit = (code_q == KEY_COMMIT);
	assign is_cancel = (code_q == KEY_CANCEL);
	assign is_delete = (code_q == KEY_DELETE);
	assign is_bksp   = (code_q == KEY_BACKSPACE);
	assign is_insert = !is_delete && (code_q >= KEY_PRINT_LO) && (code_q <= KEY_PRINT_HI);
	assign releases  = is_commit || is_cancel;

	assign left_row  = {CHAR_SPACE, work_row[ROW_W-1:8]};
	assign right_row = {work_row[ROW_W-9:0], 8'h00};

	always_comb begin
		logic [8:0] ci;
		logic [8:0] cc;
		edited_row = work_row;
		cc         = {3'd0, col_q};
		for (int i = 0; i < COLUMNS; i++) begin
			ci = 9'(i);
			if (is_delete && (ci > cc)) begin
				edited_row[i*8 +: 8] = left_row[i*8 +: 8];
			end else if (is_bksp && (ci >= cc)) begin
				edited_row[i*8 +: 8] = left_row[i*8 +: 8];
			end else if (is_insert && (ci > cc)) begin
				edited_row[i*8 +: 8] = right_row[i*8 +: 8];
			end else if (is_insert && (ci == cc)) begin
				edited_row[i*8 +: 8] = {1'b0, code_q};
			end
		end
	end

	assign work_we = cmd.exec && granted &&
		(is_cancel || (col_ok && (is_delete || is_bksp || is_insert)));
	assign cmt_we  = cmd.exec && granted && is_commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_vld_q <= '0;
			cmt_vld_q  <= '0;
			own_vld_q  <= '0;
		end else begin
			if (work_we) begin
				work_vld_q[line_addr] <= 1'b1;
			end
			if (cmt_we) begin
				cmt_vld_q[line_addr] <= 1'b1;
			end
			if (cmd.exec && granted) begin
				own_vld_q[line_addr] <= !releases;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_status_q <= granted;
			res_rel_q    <= granted && releases;
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_rel_q    <= res_rel_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_full = out_valid_q;
	assign m_tvalid     = out_valid_q;
	assign m_tdata      = {6'd0, out_rel_q, out_status_q};

endmodule
`default_nettype wire

// ----- hw/rtl/llt_checker.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// llt_checker
// Port-level checks for the line-locked text buffer, bound to the top level.
// -----------------------------------------------------------------------------
module llt_checker (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     s_tvalid,
	input wire logic                     s_tready,
	input wire logic [llt_pkg::IN_W-1:0] s_tdata,
	input wire logic                     m_tvalid,
	input wire logic                     m_tready,
	input wire logic [llt_pkg::OUT_W-1:0] m_tdata
);

	// A held result word must not change or vanish.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// A denied word never reports a released lock.
	a_deny_no_release: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[1] && !m_tdata[0]))
		else $error("lock released on a denied word");

	// Padding bits of the result word stay zero.
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:2] == 6'd0))
		else $error("result padding not zero");

	// One word at a time: no intake in the cycle after a word is taken.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a word is in progress");

endmodule

bind line_locked_text_buffer llt_checker u_llt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
